FILE: src/assert_macros.svh
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

FILE: src/icaf_pkg.sv
// Types, constants and tables for the complementary attitude filter.
// No dependencies.
package icaf_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int CW          = 36;  // CORDIC x/y width
  localparam int ZW          = 20;  // CORDIC angle width, Q16 radians
  localparam int STEPS       = 16;
  localparam int CNT_W       = 4;
  localparam int IN_SHIFT    = 14;  // inputs scaled by 16384
  localparam int MUL_A_W     = 34;
  localparam int MUL_B_W     = 18;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = 48;
  localparam int PI_Q16      = 205887;
  localparam int GAIN_Q16    = 107922;
  localparam int ALPHA_ONE   = 256;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd1;

  typedef struct packed {
    logic signed [15:0] accel_x_in;
    logic signed [15:0] accel_y_in;
    logic signed [15:0] accel_z_in;
    logic signed [15:0] rate_x_in;
    logic signed [15:0] rate_y_in;
    logic signed [15:0] rate_z_in;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] roll_out;
    logic signed [15:0] pitch_out;
    logic signed [15:0] yaw_out;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
  } cordic_cmd_t;

  typedef struct packed {
    logic                 done;
    logic signed [ZW-1:0] angle;
    logic signed [CW-1:0] mag;
  } cordic_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_YNEG, S_ROLL_GO, S_ROLL_WAIT, S_PITCH_GO, S_PITCH_WAIT,
    S_GX, S_GY, S_GZ, S_AR, S_BR, S_AP, S_BP, S_FIN, S_OUT
  } state_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [CNT_W-1:0] i);
    logic signed [ZW-1:0] v;
    begin
      case (i)
        4'd0:    v = 20'sd51472;
        4'd1:    v = 20'sd30385;
        4'd2:    v = 20'sd16054;
        4'd3:    v = 20'sd8150;
        4'd4:    v = 20'sd4091;
        4'd5:    v = 20'sd2047;
        4'd6:    v = 20'sd1024;
        4'd7:    v = 20'sd512;
        4'd8:    v = 20'sd256;
        4'd9:    v = 20'sd128;
        4'd10:   v = 20'sd64;
        4'd11:   v = 20'sd32;
        4'd12:   v = 20'sd16;
        4'd13:   v = 20'sd8;
        4'd14:   v = 20'sd4;
        default: v = 20'sd2;
      endcase
      return v;
    end
  endfunction

endpackage

FILE: src/icaf_cordic.sv
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
// Depends on icaf_pkg.
module icaf_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  icaf_pkg::cordic_cmd_t cmd,
  output icaf_pkg::cordic_res_t res
);

  logic signed [icaf_pkg::CW-1:0] x, y, dx, dy;
  logic signed [icaf_pkg::ZW-1:0] z, at;
  logic [icaf_pkg::CNT_W-1:0]     cnt;
  logic                           busy, done, zero;

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign at = icaf_pkg::atan_q16(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        zero <= (cmd.x0 == '0) && (cmd.y0 == '0);
        if (cmd.x0 < 0) begin
          // pre-rotate by pi into the right half plane
          x <= -cmd.x0;
          y <= -cmd.y0;
          z <= (cmd.y0 >= 0) ? icaf_pkg::ZW'(icaf_pkg::PI_Q16)
                             : -icaf_pkg::ZW'(icaf_pkg::PI_Q16);
        end else begin
          x <= cmd.x0;
          y <= cmd.y0;
          z <= '0;
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == icaf_pkg::CNT_W'(icaf_pkg::STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done  = done;
  assign res.angle = zero ? '0 : z;
  assign res.mag   = zero ? '0 : x;

endmodule

FILE: src/icaf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on icaf_pkg.
module icaf_mul (
  input  logic                               clk,
  input  logic signed [icaf_pkg::MUL_A_W-1:0] a,
  input  logic signed [icaf_pkg::MUL_B_W-1:0] b,
  output logic signed [icaf_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= icaf_pkg::PROD_W'(a) * icaf_pkg::PROD_W'(b);
  end

endmodule

FILE: src/imu_complementary_attitude_filter_unit.sv
// Complementary attitude filter: top level, sequencer and state.
// Depends on icaf_pkg, icaf_cordic, icaf_mul and assert_macros.svh.
//
// Usage:
//   sample_valid/sample_ready/sample carry one IMU sample (three accel axes,
//   three gyro rates). result_valid/result_ready/result return roll, pitch
//   and yaw after the update. cfg_valid/cfg_ready/cfg_index/cfg_data write
//   blend_weight (index 0) or time_step (index 1); other indexes are dropped.
//   cfg_ready is always high; write only while the block is idle.
// Sequence:
//   After a sample transfer, one CORDIC unit is run twice (roll, then pitch)
//   and one multiplier is used for eight products in turn; result_valid then
//   rises. sample_ready is high only in idle, so one sample is in flight;
//   a new sample is taken only after the result has been accepted.
// Reset:
//   rst (synchronous) clears all three angles to zero, sets blend_weight to
//   251 and time_step to 3, and returns to idle.
// Stall:
//   the result holds on result until result_ready; no new sample is taken
//   meanwhile.
`include "assert_macros.svh"
module imu_complementary_attitude_filter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  icaf_pkg::sample_t                    sample,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output icaf_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [icaf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [icaf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int FB = icaf_pkg::FRAC_BITS;

  icaf_pkg::state_t state, state_next;
  icaf_pkg::sample_t s;
  icaf_pkg::cordic_cmd_t cmd;
  icaf_pkg::cordic_res_t cres;

  logic [8:0]  blend_weight;
  logic [14:0] time_step;
  logic signed [15:0] roll, pitch, yaw, tilt_roll, tilt_pitch;
  logic signed [icaf_pkg::CW-1:0]      mag, yneg;
  logic signed [icaf_pkg::MUL_A_W-1:0] sum_r, sum_p, mul_a;
  logic signed [icaf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [icaf_pkg::PROD_W-1:0]  prod;
  logic signed [icaf_pkg::ACC_W-1:0]   acc, blend_sum;
  logic signed [icaf_pkg::MUL_A_W-1:0] yaw_sum, yaw_sh;
  logic signed [icaf_pkg::MUL_B_W-1:0] bw_op, dt_op, om_op;
  logic signed [9:0] one_minus;
  logic signed [icaf_pkg::ZW-1:0] ang_sh;

  icaf_cordic u_cordic (.clk(clk), .rst(rst), .cmd(cmd), .res(cres));
  icaf_mul    u_mul    (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  assign one_minus = 10'sd256 - $signed({1'b0, blend_weight});
  assign bw_op = icaf_pkg::MUL_B_W'($signed({1'b0, blend_weight}));
  assign dt_op = icaf_pkg::MUL_B_W'($signed({1'b0, time_step}));
  assign om_op = icaf_pkg::MUL_B_W'(one_minus);

  // Q16 angle to output scale, floor
  assign ang_sh = cres.angle >>> (16 - FB);

  // alpha*sum + ((1-alpha)*accel << FB), then floor by FB+8
  assign blend_sum = acc + (prod[icaf_pkg::ACC_W-1:0] <<< FB);
  assign yaw_sum   = (icaf_pkg::MUL_A_W'(yaw) <<< FB) + prod[icaf_pkg::MUL_A_W-1:0];
  assign yaw_sh    = yaw_sum >>> FB;

  always_comb begin
    state_next = state;
    unique case (state)
      icaf_pkg::S_IDLE:       if (sample_valid) state_next = icaf_pkg::S_YNEG;
      icaf_pkg::S_YNEG:       state_next = icaf_pkg::S_ROLL_GO;
      icaf_pkg::S_ROLL_GO:    state_next = icaf_pkg::S_ROLL_WAIT;
      icaf_pkg::S_ROLL_WAIT:  if (cres.done) state_next = icaf_pkg::S_PITCH_GO;
      icaf_pkg::S_PITCH_GO:   state_next = icaf_pkg::S_PITCH_WAIT;
      icaf_pkg::S_PITCH_WAIT: if (cres.done) state_next = icaf_pkg::S_GX;
      icaf_pkg::S_GX:         state_next = icaf_pkg::S_GY;
      icaf_pkg::S_GY:         state_next = icaf_pkg::S_GZ;
      icaf_pkg::S_GZ:         state_next = icaf_pkg::S_AR;
      icaf_pkg::S_AR:         state_next = icaf_pkg::S_BR;
      icaf_pkg::S_BR:         state_next = icaf_pkg::S_AP;
      icaf_pkg::S_AP:         state_next = icaf_pkg::S_BP;
      icaf_pkg::S_BP:         state_next = icaf_pkg::S_FIN;
      icaf_pkg::S_FIN:        state_next = icaf_pkg::S_OUT;
      icaf_pkg::S_OUT:        if (result_ready) state_next = icaf_pkg::S_IDLE;
      default:                state_next = icaf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    result_valid = 1'b0;
    cmd.start    = 1'b0;
    cmd.x0       = icaf_pkg::CW'(s.accel_z_in) <<< icaf_pkg::IN_SHIFT;
    cmd.y0       = icaf_pkg::CW'(s.accel_y_in) <<< icaf_pkg::IN_SHIFT;
    mul_a        = icaf_pkg::MUL_A_W'(s.rate_x_in);
    mul_b        = dt_op;
    unique case (state)
      icaf_pkg::S_IDLE: sample_ready = 1'b1;
      icaf_pkg::S_YNEG: begin
        mul_a = -icaf_pkg::MUL_A_W'(s.accel_x_in);
        mul_b = icaf_pkg::MUL_B_W'(icaf_pkg::GAIN_Q16);
      end
      icaf_pkg::S_ROLL_GO: cmd.start = 1'b1;
      icaf_pkg::S_PITCH_GO: begin
        cmd.start = 1'b1;
        cmd.x0    = mag;
        cmd.y0    = yneg;
      end
      icaf_pkg::S_GX: mul_a = icaf_pkg::MUL_A_W'(s.rate_x_in);
      icaf_pkg::S_GY: mul_a = icaf_pkg::MUL_A_W'(s.rate_y_in);
      icaf_pkg::S_GZ: mul_a = icaf_pkg::MUL_A_W'(s.rate_z_in);
      icaf_pkg::S_AR: begin
        mul_a = sum_r;
        mul_b = bw_op;
      end
      icaf_pkg::S_BR: begin
        mul_a = icaf_pkg::MUL_A_W'(tilt_roll);
        mul_b = om_op;
      end
      icaf_pkg::S_AP: begin
        mul_a = sum_p;
        mul_b = bw_op;
      end
      icaf_pkg::S_BP: begin
        mul_a = icaf_pkg::MUL_A_W'(tilt_pitch);
        mul_b = om_op;
      end
      icaf_pkg::S_OUT: result_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= icaf_pkg::S_IDLE;
      roll         <= '0;
      pitch        <= '0;
      yaw          <= '0;
      blend_weight <= 9'd251;
      time_step    <= 15'd3;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_index == icaf_pkg::REG_BLEND) blend_weight <= cfg_data[8:0];
      if (cfg_valid && cfg_index == icaf_pkg::REG_STEP)  time_step    <= cfg_data[14:0];
      case (state)
        icaf_pkg::S_IDLE:      if (sample_valid) s <= sample;
        icaf_pkg::S_ROLL_GO:   yneg <= prod[icaf_pkg::CW+1:2];
        icaf_pkg::S_ROLL_WAIT: if (cres.done) begin
          tilt_roll <= ang_sh[15:0];
          mag       <= cres.mag;
        end
        icaf_pkg::S_PITCH_WAIT: if (cres.done) tilt_pitch <= ang_sh[15:0];
        icaf_pkg::S_GY: sum_r <= (icaf_pkg::MUL_A_W'(roll) <<< FB)
                                 + prod[icaf_pkg::MUL_A_W-1:0];
        icaf_pkg::S_GZ: sum_p <= (icaf_pkg::MUL_A_W'(pitch) <<< FB)
                                 + prod[icaf_pkg::MUL_A_W-1:0];
        icaf_pkg::S_AR:  yaw   <= yaw_sh[15:0];
        icaf_pkg::S_BR:  acc   <= prod[icaf_pkg::ACC_W-1:0];
        icaf_pkg::S_AP:  roll  <= 16'(blend_sum >>> (FB + 8));
        icaf_pkg::S_BP:  acc   <= prod[icaf_pkg::ACC_W-1:0];
        icaf_pkg::S_FIN: pitch <= 16'(blend_sum >>> (FB + 8));
        default: ;
      endcase
    end
  end

  assign cfg_ready        = 1'b1;
  assign result.roll_out  = roll;
  assign result.pitch_out = pitch;
  assign result.yaw_out   = yaw;

  `ASSERT_IMPLIES(a_ready_excl, clk, rst, sample_ready, !result_valid)
  `ASSERT_NEXT(a_back_idle, clk, rst, result_valid && result_ready, sample_ready)
  `ASSERT_NEXT(a_cfg_blend, clk, rst, cfg_valid && cfg_index == icaf_pkg::REG_BLEND, blend_weight == $past(cfg_data[8:0]))

endmodule
